>>> hw/rtl/lse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the looping step envelope.
// No dependencies; imported by the channel interfaces and the top level.
package lse_pkg;

  // Operation carried by each input transfer
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_RELEASE = 2'd2,
    OP_WRITE   = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_STEP_SAMPLES = 3'd0,
    CFG_NUM_STEPS    = 3'd1,
    CFG_LOOP_START   = 3'd2,
    CFG_LOOP_END     = 3'd3,
    CFG_OUT_LOW      = 3'd4,
    CFG_OUT_HIGH     = 3'd5,
    CFG_IDLE_VALUE   = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StepW    = 6;
  localparam int unsigned NumW     = 7;

  // Reset values of the configuration registers
  localparam logic [15:0] StepSamplesRst = 16'd1;
  localparam logic [6:0]  NumStepsRst    = 7'd1;
  localparam logic [15:0] OutHighRst     = 16'h7FFF;

endpackage

>>> hw/rtl/lse_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the looping step envelope.
// Depends on lse_pkg for field types and widths.

// Input operations
interface lse_in_if import lse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_e                      op;
  logic [StepW-1:0]         step_addr;
  logic [SampleW-1:0]       step_value;

  modport source (output valid, op, step_addr, step_value, input ready);
  modport sink   (input valid, op, step_addr, step_value, output ready);
endinterface

// Output samples
interface lse_out_if import lse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SampleW-1:0] sample_out;
  logic                     busy_res;

  modport source (output valid, sample_out, busy_res, input ready);
  modport sink   (input valid, sample_out, busy_res, output ready);
endinterface

// Configuration writes
interface lse_cfg_if import lse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIdxW-1:0]       index;
  logic [CfgDataW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/looping_step_envelope.sv
`timescale 1ns / 1ps
// Looping step envelope: attack, looping sustain, release and done phases
// played from a step table. Depends on lse_pkg and the interfaces in lse_if.
// A tick's sample passes the table read, multiply, and round-and-saturate registers before it
// reaches the output. Throughput: one item per cycle while out_o.ready does not hold the output.
// Other operations give no sample.
// Reset clears the phase to done, the step state, the table valid bits and the
// pipeline, and loads the register defaults; no clearing pass is needed.
module looping_step_envelope import lse_pkg::*; #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  lse_in_if.sink    in_i,
  lse_out_if.source out_o,
  lse_cfg_if.sink   cfg_i
);

  // Only 64 entries are addressable by a 6-bit step index
  localparam int unsigned Depth = (MAX_STEPS < 64) ? MAX_STEPS : 64;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CWraw = $clog2(MAX_STEPS + 1);
  localparam int unsigned CW    = (CWraw > NumW) ? CWraw : NumW;
  localparam logic [CW-1:0] MaxSteps = CW'(MAX_STEPS);
  localparam logic [CW-1:0] DepthC   = CW'(Depth);

  typedef enum logic [1:0] {
    PH_DONE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  // Configuration registers
  logic [15:0]       step_samples_q;
  logic [NumW-1:0]   num_steps_q;
  logic [StepW-1:0]  loop_start_q;
  logic [StepW-1:0]  loop_end_q;
  logic signed [15:0] out_low_q;
  logic signed [15:0] out_high_q;
  logic [15:0]       idle_value_q;

  // Envelope state
  phase_e            phase_q, phase_d;
  logic [StepW-1:0]  step_index_q, step_index_d;
  logic [15:0]       sub_count_q, sub_count_d;

  // Step table with per-entry valid bits
  logic [15:0]       mem_q [Depth];
  logic [Depth-1:0]  valid_q;

  // Pipeline
  logic              s1_valid_q, s1_idle_q, s1_hit_q, s1_busy_q;
  logic [15:0]       rd_q;
  logic              s2_valid_q, s2_busy_q;
  logic signed [33:0] s2_prod_q;
  logic              o_valid_q, o_busy_q;
  logic signed [15:0] o_sample_q;

  logic o_free, s2_free, s1_free;
  logic in_acc, tick_acc, wr_en;

  assign o_free  = !o_valid_q || out_o.ready;
  assign s2_free = !s2_valid_q || o_free;
  assign s1_free = !s1_valid_q || s2_free;

  assign in_i.ready  = s1_free;
  assign cfg_i.ready = 1'b1;
  assign in_acc   = in_i.valid && s1_free;
  assign tick_acc = in_acc && (in_i.op == OP_TICK);
  assign wr_en    = in_acc && (in_i.op == OP_WRITE) && ({{(CW-StepW){1'b0}}, in_i.step_addr} < DepthC);

  // Effective hold and step count
  logic [15:0]   hold;
  logic [CW-1:0] n_eff, n_raw, si_ext, si_p1;
  logic [15:0]   sub_inc;
  logic          step_end;
  logic [StepW-1:0] si_p1_w, si_att;
  logic [CW-1:0] rd_idx;
  logic          rd_hit;

  assign hold     = (step_samples_q == 16'd0) ? 16'd1 : step_samples_q;
  assign n_raw    = (num_steps_q == '0) ? CW'(1) : CW'(num_steps_q);
  assign n_eff    = (n_raw > MaxSteps) ? MaxSteps : n_raw;
  assign sub_inc  = sub_count_q + 16'd1;
  assign step_end = (sub_inc >= hold);
  assign si_ext   = CW'(step_index_q);
  assign si_p1    = si_ext + CW'(1);
  assign si_p1_w  = step_index_q + StepW'(1);
  assign si_att   = step_end ? si_p1_w : step_index_q;

  // Next state for a tick, plus the table index it reads
  always_comb begin
    phase_d      = phase_q;
    step_index_d = step_index_q;
    sub_count_d  = sub_count_q;
    rd_idx       = si_ext;
    unique case (phase_q)
      PH_ATTACK: begin
        sub_count_d  = step_end ? 16'd0 : sub_inc;
        step_index_d = si_att;
        if (loop_start_q == '0 || si_att >= loop_start_q) begin
          phase_d      = PH_SUSTAIN;
          step_index_d = loop_start_q;
          sub_count_d  = 16'd0;
        end
      end
      PH_SUSTAIN: begin
        sub_count_d = step_end ? 16'd0 : sub_inc;
        if (step_end) begin
          step_index_d = (step_index_q >= loop_end_q) ? loop_start_q : si_p1_w;
        end
      end
      PH_RELEASE: begin
        rd_idx = (si_ext < n_eff) ? si_ext : (n_eff - CW'(1));
        if (si_ext >= n_eff) begin
          phase_d = PH_DONE;
        end else begin
          sub_count_d = step_end ? 16'd0 : sub_inc;
          if (step_end) begin
            if (si_p1 >= n_eff) phase_d = PH_DONE;
            else step_index_d = si_p1_w;
          end
        end
      end
      default: begin
        // done: state kept, idle value used
      end
    endcase
  end

  assign rd_hit = (rd_idx < DepthC) && valid_q[rd_idx[AW-1:0]];

  // Configuration, envelope state, valid bits and pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_samples_q <= StepSamplesRst;
      num_steps_q    <= NumStepsRst;
      loop_start_q   <= '0;
      loop_end_q     <= '0;
      out_low_q      <= '0;
      out_high_q     <= OutHighRst;
      idle_value_q   <= '0;
      phase_q        <= PH_DONE;
      step_index_q   <= '0;
      sub_count_q    <= '0;
      valid_q        <= '0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      o_valid_q      <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_STEP_SAMPLES: step_samples_q <= cfg_i.data;
          CFG_NUM_STEPS:    num_steps_q    <= cfg_i.data[NumW-1:0];
          CFG_LOOP_START:   loop_start_q   <= cfg_i.data[StepW-1:0];
          CFG_LOOP_END:     loop_end_q     <= cfg_i.data[StepW-1:0];
          CFG_OUT_LOW:      out_low_q      <= cfg_i.data;
          CFG_OUT_HIGH:     out_high_q     <= cfg_i.data;
          CFG_IDLE_VALUE:   idle_value_q   <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_acc) begin
        unique case (in_i.op)
          OP_TICK: begin
            phase_q      <= phase_d;
            step_index_q <= step_index_d;
            sub_count_q  <= sub_count_d;
          end
          OP_TRIGGER: begin
            phase_q      <= PH_ATTACK;
            step_index_q <= '0;
            sub_count_q  <= '0;
          end
          OP_RELEASE: phase_q <= PH_RELEASE;
          default: ;
        endcase
      end
      if (wr_en) valid_q[in_i.step_addr[AW-1:0]] <= 1'b1;
      if (s1_free) s1_valid_q <= tick_acc;
      if (s2_free) s2_valid_q <= s1_valid_q;
      if (o_free)  o_valid_q  <= s2_valid_q;
    end
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[in_i.step_addr[AW-1:0]] <= in_i.step_value;
    if (tick_acc) begin
      rd_q      <= mem_q[rd_idx[AW-1:0]];
      s1_hit_q  <= rd_hit;
      s1_idle_q <= (phase_q == PH_DONE);
      s1_busy_q <= (phase_d != PH_DONE);
    end
  end

  // Multiply stage: (out_high - out_low) * v
  logic [15:0]        v_sel;
  logic signed [16:0] diff;
  assign v_sel = s1_idle_q ? idle_value_q : (s1_hit_q ? rd_q : 16'd0);
  assign diff  = 17'(out_high_q) - 17'(out_low_q);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_free) begin
      s2_prod_q <= $signed({1'b0, v_sel}) * diff;
      s2_busy_q <= s1_busy_q;
    end
  end

  // Offset, round half up, saturate
  logic signed [34:0] sum;
  logic signed [19:0] rnd;
  logic signed [15:0] sat;
  assign sum = $signed({{4{out_low_q[15]}}, out_low_q, 15'd0}) + 35'(s2_prod_q)
             + 35'sd16384;
  assign rnd = sum[34:15];
  always_comb begin
    if (rnd > 20'sd32767)       sat = 16'sh7FFF;
    else if (rnd < -20'sd32768) sat = 16'sh8000;
    else                        sat = rnd[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && o_free) begin
      o_sample_q <= sat;
      o_busy_q   <= s2_busy_q;
    end
  end

  assign out_o.valid      = o_valid_q;
  assign out_o.sample_out = o_sample_q;
  assign out_o.busy_res   = o_busy_q;

`ifndef SYNTHESIS
  // A tick enters the pipeline, any other operation does not
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (s1_valid_q == $past(in_i.op == OP_TICK)))
    else $error("stage 1 valid does not follow accepted operation");

  // Busy flag of a tick matches the phase it leaves behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> (s1_busy_q == (phase_q != PH_DONE)))
    else $error("busy flag disagrees with phase");

  // An empty first stage always takes input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with empty first stage");

  // A product moving on while the output frees reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && o_free) |=> o_valid_q)
    else $error("sample lost between multiply and output");
`endif

endmodule
